// ----- rtl/core/aes_pkg.sv -----
`timescale 1ns / 1ps
package aes_pkg;

	localparam int RoundKeyWordsDefault = 60;
	localparam int BlockWords = 4;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 64;

	localparam logic [CfgIdxW-1:0] REG_KLEN = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_KEY0 = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_KEY1 = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_KEY2 = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_KEY3 = 3'd4;

	localparam logic CMD_ENC = 1'b0;
	localparam logic CMD_DEC = 1'b1;

	typedef struct packed {
		logic        command;
		logic [63:0] block_high;
		logic [63:0] block_low;
	} in_item_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} out_item_t;

	typedef enum logic [2:0] {
		DP_IDLE  = 3'd0,
		DP_LOAD  = 3'd1,
		DP_ROUND = 3'd2,
		DP_LAST  = 3'd3,
		DP_KLOAD = 3'd4,
		DP_KEXP  = 3'd5
	} dp_op_t;

	// controller -> datapath
	typedef struct packed {
		dp_op_t     op;
		logic       dec;
		logic [5:0] rk_rd_addr;
		logic [5:0] rk_wr_addr;
		logic       rk_wr_en;
		logic [2:0] kw_sel;
		logic [3:0] nk;
		logic       k_rot;
		logic       k_sub;
		logic       rc_step;
		logic       rc_init;
		logic       lat_out;
	} dp_cmd_t;

	function automatic logic [7:0] xt(input logic [7:0] x);
		xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] aa;
		p = 8'h00;
		aa = a;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) p = p ^ aa;
			aa = xt(aa);
		end
		gmul = p;
	endfunction

	function automatic logic [7:0] ginv(input logic [7:0] a);
		logic [7:0] r;
		logic [7:0] bs;
		r = 8'h01;
		bs = a;
		for (int k = 1; k < 8; k++) begin
			bs = gmul(bs, bs);
			r = gmul(r, bs);
		end
		ginv = r;
	endfunction

	function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
		rotl8 = (x << n) | (x >> (8 - n));
	endfunction

	function automatic logic [7:0] sbox_calc(input logic [7:0] b);
		logic [7:0] r;
		r = ginv(b);
		sbox_calc = r ^ rotl8(r, 1) ^ rotl8(r, 2) ^ rotl8(r, 3) ^ rotl8(r, 4) ^ 8'h63;
	endfunction

	function automatic logic [7:0] inv_sbox_calc(input logic [7:0] b);
		inv_sbox_calc = ginv(rotl8(b, 1) ^ rotl8(b, 3) ^ rotl8(b, 6) ^ 8'h05);
	endfunction

	// constant tables, folded at elaboration
	function automatic logic [255:0][7:0] sbox_table(input logic inv);
		logic [255:0][7:0] t;
		for (int i = 0; i < 256; i++) begin
			t[i] = inv ? inv_sbox_calc(8'(i)) : sbox_calc(8'(i));
		end
		sbox_table = t;
	endfunction

	localparam logic [255:0][7:0] SBOX = sbox_table(1'b0);
	localparam logic [255:0][7:0] ISBOX = sbox_table(1'b1);

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

endpackage

// ----- rtl/core/aes_block_cipher_core.sv -----
`timescale 1ns / 1ps
// AES-128/192/256 encrypt/decrypt core, one block at a time.
// Flow: a transferred block passes S_PRE, the S_RUN round loop and S_DONE, which
// latches the result; a block after a key change first expands 4*(Nr+1)
// schedule words, one schedule word per cycle.
// A new block is taken only in idle, so blocks pass the single shared round unit
// one at a time; a stalled result waits in the output register while the next block runs.
// Reset: async active-low; key registers clear to zero, schedule marked stale.
module aes_block_cipher_core
	import aes_pkg::*;
#(
	parameter int RoundKeyWords = RoundKeyWordsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  in_item_t            in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output out_item_t           out_data,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);
	logic [1:0]       klen_q;
	logic [3:0][63:0] key_q;
	logic             cfg_clear;
	dp_cmd_t          cmd;
	in_item_t         in_q;

	// config registers; any valid write invalidates the key schedule
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q <= '0;
			key_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KLEN: klen_q <= cfg_data[1:0];
				REG_KEY0: key_q[0] <= cfg_data;
				REG_KEY1: key_q[1] <= cfg_data;
				REG_KEY2: key_q[2] <= cfg_data;
				REG_KEY3: key_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg_clear = cfg_we && (cfg_index <= REG_KEY3);

	// capture the block on transfer; held until the round loop loads it
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) in_q <= in_data;
	end

	aes_ctrl #(.RoundKeyWords(RoundKeyWords)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_dec   (in_data.command == CMD_DEC),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cfg_clear(cfg_clear),
		.klen_q   (klen_q),
		.cmd      (cmd)
	);

	aes_datapath #(.RoundKeyWords(RoundKeyWords)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_item (in_q),
		.key_q   (key_q),
		.out_item(out_data)
	);
endmodule

// ----- rtl/core/aes_ram.sv -----
`timescale 1ns / 1ps
module aes_ram #(
	parameter int Width = 32,
	parameter int Depth = 60
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]         rd_data
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		rd_data <= mem_q[rd_addr];
	end
endmodule

// ----- rtl/core/aes_datapath.sv -----
`timescale 1ns / 1ps
module aes_datapath
	import aes_pkg::*;
#(
	parameter int RoundKeyWords = RoundKeyWordsDefault
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dp_cmd_t                          cmd,
	input  in_item_t                         in_item,
	input  logic [3:0][63:0]                 key_q,
	output out_item_t                        out_item
);
	localparam int AW = $clog2(RoundKeyWords);

	logic [7:0][31:0] kwin_q;   // sliding window of last 8 schedule words
	logic [7:0]       rc_q;
	logic [127:0]     state_q;
	logic [127:0]     rk;
	logic [31:0]      new_word;
	logic [31:0]      t;
	logic [31:0]      prev;
	logic [31:0]      back;
	logic [127:0]     rnd;
	logic [AW-1:0]    rd_a;
	logic [AW-1:0]    wr_a;

	// four banks, one per column: word 4*round+c sits in bank c at row round,
	// so a whole round key comes out of one read
	logic [3:0][31:0] bank_rd;

	assign rd_a = AW'(cmd.rk_rd_addr);
	assign wr_a = AW'(cmd.rk_wr_addr);

	localparam int BankDepth = (RoundKeyWords + 3) / 4;
	localparam int BW = $clog2(BankDepth);

	for (genvar b = 0; b < 4; b++) begin : g_bank
		aes_ram #(.Width(32), .Depth(BankDepth)) u_ram (
			.clk    (clk),
			.wr_en  (cmd.rk_wr_en && wr_a[1:0] == 2'(b)),
			.wr_addr(BW'(wr_a >> 2)),
			.wr_data(new_word),
			.rd_addr(BW'(rd_a)),
			.rd_data(bank_rd[b])
		);
	end

	assign rk = {bank_rd[0], bank_rd[1], bank_rd[2], bank_rd[3]};
	assign prev = kwin_q[0];
	assign back = kwin_q[3'(cmd.nk - 4'd1)];

	// key expansion word
	always_comb begin
		t = prev;
		if (cmd.k_rot) t = sub_word({prev[23:0], prev[31:24]}) ^ {rc_q, 24'h0};
		else if (cmd.k_sub) t = sub_word(prev);
		new_word = back ^ t;
		if (cmd.op == DP_KLOAD) new_word = 32'(key_q[cmd.kw_sel[2:1]] >> (cmd.kw_sel[0] ? 0 : 32));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q <= 8'h01;
		end else if (cmd.rc_init) begin
			rc_q <= 8'h01;
		end else if (cmd.rc_step) begin
			rc_q <= xt(rc_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rk_wr_en) kwin_q <= {kwin_q[6:0], new_word};
	end

	// round function
	function automatic logic [127:0] fwd_round(input logic [127:0] s, input logic mix);
		logic [15:0][7:0] a;
		logic [15:0][7:0] b;
		logic [15:0][7:0] o;
		for (int i = 0; i < 16; i++) a[i] = s[127-8*i -: 8];
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				b[4*c+r] = SBOX[a[4*((c+r)%4)+r]];
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				o[4*c+r] = mix ? (gmul(8'h02, b[4*c+r]) ^ gmul(8'h03, b[4*c+(r+1)%4])
					^ b[4*c+(r+2)%4] ^ b[4*c+(r+3)%4]) : b[4*c+r];
		for (int i = 0; i < 16; i++) fwd_round[127-8*i -: 8] = o[i];
	endfunction

	function automatic logic [127:0] inv_round(input logic [127:0] s, input logic [127:0] k,
		input logic mix);
		logic [15:0][7:0] a;
		logic [15:0][7:0] b;
		logic [15:0][7:0] o;
		for (int i = 0; i < 16; i++) a[i] = s[127-8*i -: 8];
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				b[4*c+r] = ISBOX[a[4*((c+4-r)%4)+r]] ^ k[127-8*(4*c+r) -: 8];
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				o[4*c+r] = mix ? (gmul(8'h0e, b[4*c+r]) ^ gmul(8'h0b, b[4*c+(r+1)%4])
					^ gmul(8'h0d, b[4*c+(r+2)%4]) ^ gmul(8'h09, b[4*c+(r+3)%4]))
					: b[4*c+r];
		for (int i = 0; i < 16; i++) inv_round[127-8*i -: 8] = o[i];
	endfunction

	always_comb begin
		unique case (cmd.op)
			DP_LOAD:  rnd = {in_item.block_high, in_item.block_low} ^ rk;
			DP_ROUND: rnd = cmd.dec ? inv_round(state_q, rk, 1'b1) : fwd_round(state_q, 1'b1) ^ rk;
			DP_LAST:  rnd = cmd.dec ? inv_round(state_q, rk, 1'b0) : fwd_round(state_q, 1'b0) ^ rk;
			default:  rnd = state_q;
		endcase
	end

	always_ff @(posedge clk) begin
		state_q <= rnd;
		if (cmd.lat_out) out_item <= {state_q[127:64], state_q[63:0]};
	end
endmodule

// ----- rtl/core/aes_ctrl.sv -----
`timescale 1ns / 1ps
module aes_ctrl
	import aes_pkg::*;
#(
	parameter int RoundKeyWords = RoundKeyWordsDefault
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  logic     in_dec,
	output logic     out_valid,
	input  logic     out_stall,
	input  logic     cfg_clear,
	input  logic [1:0] klen_q,
	output dp_cmd_t  cmd
);
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_KEXP  = 6'b000010,
		S_PRE   = 6'b000100,
		S_RUN   = 6'b001000,
		S_DONE  = 6'b010000,
		S_OUT   = 6'b100000
	} st_t;

	st_t        st_q;
	logic       ready_q;
	logic       dec_q;
	logic [5:0] i_q;
	logic [3:0] r_q;
	logic [3:0] nr_q;
	logic [3:0] nk_q;
	logic [2:0] mod_q;
	logic [1:0] sel;
	logic [3:0] nk_c;
	logic [3:0] nr_c;
	logic [5:0] total;
	logic [3:0] rd_round;
	logic       out_free;

	always_comb begin
		sel = (klen_q == 2'd3) ? 2'd2 : klen_q;
		if (sel == 2'd2 && RoundKeyWords < 60) sel = 2'd1;
		if (sel == 2'd1 && RoundKeyWords < 52) sel = 2'd0;
		nk_c = 4'd4 + {1'b0, sel, 1'b0};
		nr_c = 4'd10 + {1'b0, sel, 1'b0};
	end

	assign total = {nr_q, 2'b00} + 6'd4;
	assign in_stall = (st_q != S_IDLE);
	// output register can take a new result this cycle
	assign out_free = !out_valid || !out_stall;

	// round key row address for current step
	always_comb begin
		unique case (st_q)
			S_PRE:   rd_round = dec_q ? nr_q : 4'd0;
			S_RUN:   rd_round = (r_q == nr_q) ? 4'd0
				: (dec_q ? nr_q - r_q - 4'd1 : r_q + 4'd1);
			default: rd_round = 4'd0;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.dec = dec_q;
		cmd.nk = nk_q;
		cmd.rk_rd_addr = {2'b00, rd_round};
		cmd.rk_wr_addr = i_q;
		unique case (st_q)
			S_IDLE: begin
				cmd.rc_init = 1'b1;
				cmd.op = DP_IDLE;
			end
			S_KEXP: begin
				cmd.rk_wr_en = 1'b1;
				if (i_q < {2'b00, nk_q}) begin
					cmd.op = DP_KLOAD;
					cmd.kw_sel = i_q[2:0];
				end else begin
					cmd.op = DP_KEXP;
					cmd.k_rot = (mod_q == 3'd0);
					cmd.k_sub = (nk_q == 4'd8) && (mod_q == 3'd4);
					cmd.rc_step = cmd.k_rot;
				end
			end
			S_PRE: cmd.op = DP_IDLE;
			S_RUN: begin
				if (r_q == 4'd0) cmd.op = DP_LOAD;
				else if (r_q == nr_q) cmd.op = DP_LAST;
				else cmd.op = DP_ROUND;
			end
			S_DONE: cmd.lat_out = out_free;
			default: cmd.op = DP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ready_q <= 1'b0;
			out_valid <= 1'b0;
			dec_q <= 1'b0;
			i_q <= '0;
			r_q <= '0;
			nr_q <= 4'd10;
			nk_q <= 4'd4;
			mod_q <= '0;
		end else begin
			if (cfg_clear) ready_q <= 1'b0;
			if (st_q == S_DONE && out_free) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (st_q)
				S_IDLE: if (in_valid && !in_stall) begin
					dec_q <= in_dec;
					i_q <= '0;
					mod_q <= '0;
					if (!ready_q) begin
						nk_q <= nk_c;
						nr_q <= nr_c;
						st_q <= S_KEXP;
					end else begin
						st_q <= S_PRE;
					end
				end
				S_KEXP: begin
					i_q <= i_q + 6'd1;
					mod_q <= (mod_q + 3'd1 == nk_q[2:0] && nk_q != 4'd8) || mod_q == 3'd7
						? 3'd0 : mod_q + 3'd1;
					if (i_q + 6'd1 == total) begin
						ready_q <= 1'b1;
						st_q <= S_PRE;
					end
				end
				S_PRE: begin
					r_q <= '0;
					st_q <= S_RUN;
				end
				S_RUN: begin
					r_q <= r_q + 4'd1;
					if (r_q == nr_q) st_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
